// ===== rtl/cshf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cshf_pkg: shared types and constants of the command secondary header framer
// Item structs for both channels, the controller/datapath command and status
// bundles, and the header checksum helper.
// ----------------------------------------------------------------------------
package cshf_pkg;

    // Default payload buffer depth in bytes.
    localparam int unsigned PAYLOAD_DEPTH_DEF = 62;

    // Checksum seed value.
    localparam logic [7:0] CHK_SEED = 8'hFF;
    // First primary header byte above the APID: version 0, command type,
    // secondary header flag set.
    localparam logic [7:0] HDR_ID_HI = 8'h18;
    // Sequence flags for an unsegmented packet.
    localparam logic [1:0] SEQ_FLAGS_UNSEG = 2'h3;

    // One input item.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_present;
        logic        frame_end;
        logic [10:0] apid;
        logic [13:0] seq_count;
        logic [7:0]  function_code;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       status;
    } out_item_t;

    // Source of the next value loaded into the output register.
    typedef enum logic [1:0] {
        SEL_OVF   = 2'd0,
        SEL_FCODE = 2'd1,
        SEL_SUM   = 2'd2,
        SEL_PAY   = 2'd3
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     take;
        logic     load;
        out_sel_t sel;
        logic     rd_en;
        logic     rd_adv;
    } cshf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_ovf;
        logic empty;
        logic pay_last;
        logic out_free;
    } cshf_sts_t;

    // XOR of the checksum seed and the six predicted primary header bytes.
    // The high length byte is always zero for this buffer size.
    function automatic logic [7:0] hdr_xor(
        input logic [10:0] apid,
        input logic [13:0] seq,
        input logic [7:0]  len
    );
        logic [7:0] acc;
        acc = CHK_SEED;
        acc = acc ^ (HDR_ID_HI | {5'b0, apid[10:8]});
        acc = acc ^ apid[7:0];
        acc = acc ^ {SEQ_FLAGS_UNSEG, seq[13:8]};
        acc = acc ^ seq[7:0];
        acc = acc ^ len;
        return acc;
    endfunction

endpackage

// ===== rtl/command_secondary_header_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_secondary_header_framer: command packet framer with XOR checksum
// Buffers a command payload and emits function code, checksum and payload.
// ----------------------------------------------------------------------------
// Payload items are taken at one per cycle while a frame is collected. The
// item with frame_end set closes the frame; the block then stops taking
// input until its last result is in the output register. A frame with N
// stored bytes emits the function code, then the checksum, then the N
// payload bytes; each payload byte is first read from the buffer's single
// registered read port and then loaded into the output register. An
// overflowed frame emits one status result. The output register lets a new
// frame start while the final result still waits to be taken. No clearing
// pass is needed after reset.
module command_secondary_header_framer #(
    parameter int unsigned MAX_PAYLOAD = cshf_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cshf_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cshf_pkg::out_item_t out_data
);
    import cshf_pkg::*;

    cshf_cmd_t cmd;
    cshf_sts_t sts;

    // Controller.
    cshf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.frame_end),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    cshf_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== rtl/cshf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cshf_ctrl: framer controller
// One-hot state machine that collects a frame and then sequences the output
// of function code, checksum and buffered payload, or of one overflow status result.
// ----------------------------------------------------------------------------
module cshf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  cshf_pkg::cshf_sts_t sts,
    output cshf_pkg::cshf_cmd_t cmd
);
    import cshf_pkg::*;

    typedef enum logic [5:0] {
        S_COLLECT = 6'b000001,
        S_OVF     = 6'b000010,
        S_FCODE   = 6'b000100,
        S_SUM     = 6'b001000,
        S_READ    = 6'b010000,
        S_PAY     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.sel    = SEL_OVF;
        case (state_reg)
            S_COLLECT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (in_last)
                    begin
                        state_next = sts.frame_ovf ? S_OVF : S_FCODE;
                    end
                end
            end
            S_OVF:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SEL_OVF;
                    state_next = S_COLLECT;
                end
            end
            S_FCODE:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SEL_FCODE;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SEL_SUM;
                    state_next = sts.empty ? S_COLLECT : S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_PAY;
            end
            S_PAY:
            begin
                if (sts.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.sel  = SEL_PAY;
                    if (sts.pay_last)
                    begin
                        state_next = S_COLLECT;
                    end
                    else
                    begin
                        cmd.rd_adv = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

endmodule

// ===== rtl/cshf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cshf_dp: framer datapath
// Payload buffer, byte count, running XOR, checksum capture and the output
// register that feeds the result channel.
// ----------------------------------------------------------------------------
module cshf_dp #(
    parameter int unsigned MAX_PAYLOAD = cshf_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cshf_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cshf_pkg::out_item_t out_data,
    input  cshf_pkg::cshf_cmd_t cmd,
    output cshf_pkg::cshf_sts_t sts
);
    import cshf_pkg::*;

    localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]    payload_mem [MAX_PAYLOAD];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    xor_reg;
    logic [7:0]    xor_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [CW-1:0] emit_cnt_reg;
    logic [7:0]    fcode_reg;
    logic [7:0]    sum_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [7:0]    rd_data_reg;
    logic          out_valid_reg;
    out_item_t     out_data_reg;
    out_item_t     out_data_next;

    logic          has_room;
    logic          do_write;
    logic [7:0]    sum_next;

    // Frame accumulation including the item being taken.
    always_comb
    begin
        has_room   = (count_reg < CW'(MAX_PAYLOAD));
        do_write   = cmd.take && in_data.byte_present && has_room;
        count_next = do_write ? count_reg + CW'(1) : count_reg;
        xor_next   = do_write ? (xor_reg ^ in_data.payload_byte) : xor_reg;
        ovf_next   = ovf_reg || (in_data.byte_present && !has_room);
        sum_next   = hdr_xor(in_data.apid, in_data.seq_count, 8'(count_next) + 8'd1)
                     ^ in_data.function_code ^ xor_next;
    end

    // Frame counters, cleared after the final item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            xor_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.take)
        begin
            if (in_data.frame_end)
            begin
                count_reg <= '0;
                xor_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                xor_reg   <= xor_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Header results captured on the final item.
    always_ff @(posedge clk)
    begin
        if (cmd.take && in_data.frame_end)
        begin
            emit_cnt_reg <= count_next;
            fcode_reg    <= in_data.function_code;
            sum_reg      <= sum_next;
        end
    end

    // Payload buffer: one write port while collecting, registered read.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            payload_mem[count_reg[AW-1:0]] <= in_data.payload_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= payload_mem[rd_idx_reg];
        end
    end

    // Read pointer for the payload drain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.take && in_data.frame_end)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.rd_adv)
        begin
            rd_idx_reg <= rd_idx_reg + AW'(1);
        end
    end

    // Status back to the controller.
    always_comb
    begin
        sts.frame_ovf = ovf_next;
        sts.empty     = (emit_cnt_reg == '0);
        sts.pay_last  = ((CW'(rd_idx_reg) + CW'(1)) == emit_cnt_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // Output mux.
    always_comb
    begin
        out_data_next = '0;
        case (cmd.sel)
            SEL_OVF:
            begin
                out_data_next.out_byte = 8'h00;
                out_data_next.out_last = 1'b1;
                out_data_next.status   = 1'b1;
            end
            SEL_FCODE:
            begin
                out_data_next.out_byte = fcode_reg;
            end
            SEL_SUM:
            begin
                out_data_next.out_byte = sum_reg;
                out_data_next.out_last = sts.empty;
            end
            SEL_PAY:
            begin
                out_data_next.out_byte = rd_data_reg;
                out_data_next.out_last = sts.pay_last;
            end
            default:
            begin
                out_data_next = '0;
            end
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/cshf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cshf_checker: port-level checks for the framer
// Watches the channels of the top level over time; bound to the top level.
// ----------------------------------------------------------------------------
module cshf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input cshf_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input cshf_pkg::out_item_t out_data
);
    import cshf_pkg::*;

    // A stalled result holds its value until the transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A dropped-frame result is a single zero byte marked last.
    a_ovf_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.out_last && out_data.out_byte == 8'h00)
        else $error("malformed overflow result");

    // Input is closed while a frame is still being emitted.
    a_no_in_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.out_last |-> !in_ready)
        else $error("input open during frame emission");

    // Closing a frame stops input for at least the next cycle.
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.frame_end |=> !in_ready)
        else $error("input open right after frame end");

endmodule

bind command_secondary_header_framer cshf_checker u_cshf_checker (.*);
